// File: hw/rtl/cpu_alu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_pkg
// Operation codes shared by the 8-bit ALU with flag outputs.
// ----------------------------------------------------------------------------
package cpu_alu_pkg;

  localparam int unsigned ActionWidth = 4;
  localparam int unsigned DataWidth   = 16;
  localparam int unsigned ByteWidth   = 8;

  typedef enum logic [ActionWidth-1:0] {
    ACT_ADD = 4'd0,
    ACT_ADC = 4'd1,
    ACT_SUB = 4'd2,
    ACT_SBC = 4'd3,
    ACT_AND = 4'd4,
    ACT_XOR = 4'd5,
    ACT_OR  = 4'd6,
    ACT_CP  = 4'd7,
    ACT_INC = 4'd8,
    ACT_DEC = 4'd9
  } act_t;

endpackage : cpu_alu_pkg
`default_nettype wire

// File: hw/rtl/cpu_alu_with_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit CPU ALU with Z/N/H/C flag outputs and 16-bit add, inc and dec.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation word: action,
//   wide flag, two operands, current carry and keep-carry. Output channel
//   (out_valid/out_ready) returns one result word per input word: result,
//   write enables, the four flags and an illegal-operation marker.
//   Path: the word is captured in the input register when accepted,
//   evaluated by the flag and adder logic, and loaded into the result
//   register once that register is empty or being drained; out_valid
//   rises with that load. Throughput: one word per cycle while out_ready
//   is high. Input and result registers advance together, so the block
//   keeps taking words while results drain.
//   Stall: when out_ready is low the result register holds, the input
//   register holds its word behind it, and in_ready drops once both are
//   full. No word is lost or repeated.
//   Reset (rst_n low, synchronous) empties both registers; the ALU has no
//   other state.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_action,
  input  wire logic        in_is_wide,
  input  wire logic [15:0] in_first,
  input  wire logic [15:0] in_second,
  input  wire logic        in_carry_in,
  input  wire logic        in_keep_carry,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result,
  output logic             out_write_result,
  output logic             out_flags_valid,
  output logic             out_zero_flag,
  output logic             out_subtract_flag,
  output logic             out_half_flag,
  output logic             out_carry_flag_out,
  output logic             out_carry_valid,
  output logic             out_illegal
);

  typedef struct packed {
    logic [15:0] result;
    logic        write_result;
    logic        flags_valid;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_flag;
    logic        carry_flag_out;
    logic        carry_valid;
    logic        illegal;
  } res_t;

  // Input register
  logic                s1_valid_r;
  cpu_alu_pkg::act_t   s1_action_r;
  logic                s1_is_wide_r;
  logic [15:0]         s1_first_r;
  logic [15:0]         s1_second_r;
  logic                s1_carry_in_r;
  logic                s1_keep_carry_r;

  // Result register
  logic                out_valid_r;
  res_t                out_res_r;
  res_t                out_res_nxt;

  logic                out_load;
  logic                in_load;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign in_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_action_r     <= cpu_alu_pkg::act_t'(in_action);
      s1_is_wide_r    <= in_is_wide;
      s1_first_r      <= in_first;
      s1_second_r     <= in_second;
      s1_carry_in_r   <= in_carry_in;
      s1_keep_carry_r <= in_keep_carry;
    end
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  // Datapath
  logic [7:0]  a_lo, b_lo, a_hi, b_hi;
  logic        ci;
  logic [8:0]  add9, sub9, lo9, hi9;
  logic [4:0]  add_nib, sub_nib, hi_nib;
  logic [15:0] w_inc, w_dec;

  assign a_lo = s1_first_r[7:0];
  assign b_lo = s1_second_r[7:0];
  assign a_hi = s1_first_r[15:8];
  assign b_hi = s1_second_r[15:8];
  assign ci   = ((s1_action_r == cpu_alu_pkg::ACT_ADC) ||
                 (s1_action_r == cpu_alu_pkg::ACT_SBC)) ? s1_carry_in_r : 1'b0;

  assign add9    = {1'b0, a_lo} + {1'b0, b_lo} + {8'd0, ci};
  assign sub9    = {1'b0, a_lo} - {1'b0, b_lo} - {8'd0, ci};
  // Bit 4 of the nibble sums is the half carry or half borrow.
  assign add_nib = {1'b0, a_lo[3:0]} + {1'b0, b_lo[3:0]} + {4'd0, ci};
  assign sub_nib = {1'b0, a_lo[3:0]} - {1'b0, b_lo[3:0]} - {4'd0, ci};

  // Wide add: two byte adds, carry passed into the high half
  assign lo9    = {1'b0, a_lo} + {1'b0, b_lo};
  assign hi9    = {1'b0, a_hi} + {1'b0, b_hi} + {8'd0, lo9[8]};
  assign hi_nib = {1'b0, a_hi[3:0]} + {1'b0, b_hi[3:0]} + {4'd0, lo9[8]};

  assign w_inc = s1_first_r + s1_second_r;
  assign w_dec = s1_first_r - s1_second_r;

  always_comb begin
    logic [7:0] r8;
    logic       h;
    logic       c;
    logic       n;
    logic       bad;

    r8  = 8'd0;
    h   = 1'b0;
    c   = 1'b0;
    n   = 1'b0;
    bad = 1'b0;
    out_res_nxt = '0;

    case (s1_action_r)
      cpu_alu_pkg::ACT_ADD, cpu_alu_pkg::ACT_ADC, cpu_alu_pkg::ACT_INC: begin
        r8 = add9[7:0];
        h  = add_nib[4];
        c  = add9[8];
      end
      cpu_alu_pkg::ACT_SUB, cpu_alu_pkg::ACT_SBC, cpu_alu_pkg::ACT_CP,
      cpu_alu_pkg::ACT_DEC: begin
        r8 = sub9[7:0];
        h  = sub_nib[4];
        c  = sub9[8];
        n  = 1'b1;
      end
      cpu_alu_pkg::ACT_AND: begin
        r8 = a_lo & b_lo;
        h  = 1'b1;
      end
      cpu_alu_pkg::ACT_XOR: r8 = a_lo ^ b_lo;
      cpu_alu_pkg::ACT_OR:  r8 = a_lo | b_lo;
      default:              bad = 1'b1;
    endcase

    if (bad) begin
      out_res_nxt.illegal = 1'b1;
    end else if (s1_is_wide_r) begin
      case (s1_action_r)
        cpu_alu_pkg::ACT_ADD: begin
          out_res_nxt.result         = {hi9[7:0], lo9[7:0]};
          out_res_nxt.write_result   = 1'b1;
          out_res_nxt.flags_valid    = 1'b1;
          out_res_nxt.zero_flag      = (hi9[7:0] == 8'd0);
          out_res_nxt.half_flag      = hi_nib[4];
          out_res_nxt.carry_flag_out = hi9[8];
          out_res_nxt.carry_valid    = 1'b1;
        end
        cpu_alu_pkg::ACT_INC: begin
          out_res_nxt.result       = w_inc;
          out_res_nxt.write_result = 1'b1;
        end
        cpu_alu_pkg::ACT_DEC: begin
          out_res_nxt.result       = w_dec;
          out_res_nxt.write_result = 1'b1;
        end
        default: out_res_nxt.illegal = 1'b1;
      endcase
    end else begin
      out_res_nxt.result         = {8'd0, r8};
      out_res_nxt.write_result   = (s1_action_r != cpu_alu_pkg::ACT_CP);
      out_res_nxt.flags_valid    = 1'b1;
      out_res_nxt.zero_flag      = (r8 == 8'd0);
      out_res_nxt.subtract_flag  = n;
      out_res_nxt.half_flag      = h;
      out_res_nxt.carry_flag_out = s1_keep_carry_r ? 1'b0 : c;
      out_res_nxt.carry_valid    = !s1_keep_carry_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_res_r.result;
  assign out_write_result   = out_res_r.write_result;
  assign out_flags_valid    = out_res_r.flags_valid;
  assign out_zero_flag      = out_res_r.zero_flag;
  assign out_subtract_flag  = out_res_r.subtract_flag;
  assign out_half_flag      = out_res_r.half_flag;
  assign out_carry_flag_out = out_res_r.carry_flag_out;
  assign out_carry_valid    = out_res_r.carry_valid;
  assign out_illegal        = out_res_r.illegal;

  // An illegal word writes nothing.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_illegal) |-> (!out_write_result && !out_flags_valid &&
                                    !out_carry_valid && (out_result == 16'd0)))
    else $error("illegal word carries writes");

  // Carry is never written without the other flags.
  a_carry_needs_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_carry_valid) |-> out_flags_valid)
    else $error("carry written without flags");

  // A word in the input register stays there until it moves to the output.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("input register word dropped");

  // A result taken while the input register is empty leaves the output empty.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !s1_valid_r) |=> !out_valid)
    else $error("result repeated");

endmodule : cpu_alu_with_flags
`default_nettype wire
